### hw/rtl/bodc_pkg.sv
`timescale 1ns / 1ps
// Package for the box overlay and decimating crop block.
// Frame geometry, box table sizing, shared types. No dependencies.
package bodc_pkg;

  localparam int FRAME_WIDTH  = 1920;
  localparam int FRAME_HEIGHT = 1080;
  localparam int BOX_SLOTS    = 16;
  localparam int GRID_SIZE    = 160;

  localparam int POS_W     = 11;
  localparam int COORD_W   = 12;
  localparam int CROP_W    = 11;
  localparam int PIX_W     = 24;
  localparam int BYTE_W    = 8;
  localparam int GRID_W    = 8;
  localparam int BOX_IDX_W = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;
  localparam int BOX_CNT_W = $clog2(BOX_SLOTS + 1);
  localparam int BOX_BYTES = 16;

  localparam logic [POS_W-1:0]  LAST_COL  = POS_W'(FRAME_WIDTH - 1);
  localparam logic [POS_W-1:0]  LAST_ROW  = POS_W'(FRAME_HEIGHT - 1);
  localparam logic [POS_W-1:0]  WIN_SPAN  = POS_W'(4 * GRID_SIZE);
  localparam logic [GRID_W-1:0] GRID_LAST = GRID_W'(GRID_SIZE - 1);
  localparam logic [PIX_W-1:0]  RED_PIXEL = 24'hff0000;

  typedef enum logic {
    REG_CROP_X0 = 1'b0,
    REG_CROP_Y0 = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DET   = 1'b1
  } command_e;

  typedef struct packed {
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
  } box_t;

  typedef struct packed {
    logic frame_start;
    logic line_end;
    logic sample_valid;
    logic sample_last;
  } raster_tag_t;

endpackage

### hw/rtl/bodc_boxes.sv
`timescale 1ns / 1ps
// Detection stream parser, box table and parallel box hit test.
// Depends on bodc_pkg.
module bodc_boxes
  import bodc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              det_step_i,
  input  logic [BYTE_W-1:0] det_byte_i,
  input  logic [CROP_W-1:0] crop_x0_i,
  input  logic [CROP_W-1:0] crop_y0_i,
  input  logic [POS_W-1:0]  x_i,
  input  logic [POS_W-1:0]  y_i,
  output logic              hit_o
);

  box_t                 table_q [BOX_SLOTS];
  logic [BOX_CNT_W-1:0] box_count_q;
  logic [7:0]           entry_q;
  logic [3:0]           byte_q;
  logic [7:0]           total_q;
  logic                 expect_q;

  logic [COORD_W-1:0]   coord;
  logic [7:0]           entry_inc;
  logic                 slot_ok;

  assign coord = COORD_W'({det_byte_i, 2'b00})
               + COORD_W'(byte_q[0] ? crop_y0_i : crop_x0_i);
  assign entry_inc = entry_q + 8'd1;
  assign slot_ok = entry_q < 8'(BOX_SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_count_q <= '0;
      entry_q     <= '0;
      byte_q      <= '0;
      total_q     <= '0;
      expect_q    <= 1'b1;
    end else if (det_step_i) begin
      if (expect_q) begin
        total_q     <= det_byte_i;
        entry_q     <= '0;
        byte_q      <= '0;
        box_count_q <= '0;
        expect_q    <= (det_byte_i == '0);
      end else if (byte_q == 4'(BOX_BYTES - 1)) begin
        byte_q <= '0;
        if (slot_ok) begin
          box_count_q <= BOX_CNT_W'(entry_inc);
        end
        entry_q <= entry_inc;
        if (entry_inc >= total_q) begin
          expect_q <= 1'b1;
        end
      end else begin
        byte_q <= byte_q + 4'd1;
      end
    end
  end

  // table entries hold no reset: only completed entries are ever tested
  always_ff @(posedge clk_i) begin
    if (det_step_i && !expect_q && slot_ok) begin
      unique case (byte_q)
        4'd0:    table_q[entry_q[BOX_IDX_W-1:0]].x1 <= coord;
        4'd1:    table_q[entry_q[BOX_IDX_W-1:0]].y1 <= coord;
        4'd2:    table_q[entry_q[BOX_IDX_W-1:0]].x2 <= coord;
        4'd3:    table_q[entry_q[BOX_IDX_W-1:0]].y2 <= coord;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    xe = COORD_W'(x_i);
    ye = COORD_W'(y_i);
    hit_o = 1'b0;
    for (int i = 0; i < BOX_SLOTS; i++) begin
      if ((BOX_CNT_W'(i) < box_count_q) &&
          xe >= table_q[i].x1 && xe < table_q[i].x2 &&
          ye >= table_q[i].y1 && ye < table_q[i].y2) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

### hw/rtl/bodc_raster.sv
`timescale 1ns / 1ps
// Raster position counters, window decimation and grid sample counters.
// Depends on bodc_pkg.
module bodc_raster
  import bodc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_step_i,
  input  logic [CROP_W-1:0] crop_x0_i,
  input  logic [CROP_W-1:0] crop_y0_i,
  output logic [POS_W-1:0]  x_o,
  output logic [POS_W-1:0]  y_o,
  output raster_tag_t       tag_o
);

  logic [POS_W-1:0]  col_q, row_q;
  logic [GRID_W-1:0] scol_q, srow_q;
  logic [GRID_W-1:0] scol, srow;
  logic [POS_W-1:0]  dx, dy;
  logic              first, in_win;

  assign x_o   = col_q;
  assign y_o   = row_q;
  assign first = (col_q == '0) && (row_q == '0);
  assign scol  = first ? '0 : scol_q;
  assign srow  = first ? '0 : srow_q;
  assign dx    = col_q - POS_W'(crop_x0_i);
  assign dy    = row_q - POS_W'(crop_y0_i);

  assign in_win = (col_q >= POS_W'(crop_x0_i)) && (dx < WIN_SPAN) &&
                  (row_q >= POS_W'(crop_y0_i)) && (dy < WIN_SPAN) &&
                  (dx[1:0] == 2'b00) && (dy[1:0] == 2'b00);

  assign tag_o.frame_start  = first;
  assign tag_o.line_end     = (col_q == LAST_COL);
  assign tag_o.sample_valid = in_win;
  assign tag_o.sample_last  = in_win && (scol == GRID_LAST) && (srow == GRID_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      scol_q <= '0;
      srow_q <= '0;
    end else if (pix_step_i) begin
      if (col_q == LAST_COL) begin
        col_q <= '0;
        row_q <= (row_q == LAST_ROW) ? '0 : row_q + POS_W'(1);
      end else begin
        col_q <= col_q + POS_W'(1);
      end
      if (in_win) begin
        if (scol == GRID_LAST) begin
          scol_q <= '0;
          srow_q <= (srow == GRID_LAST) ? '0 : srow + GRID_W'(1);
        end else begin
          scol_q <= scol + GRID_W'(1);
          srow_q <= srow;
        end
      end else begin
        scol_q <= scol;
        srow_q <= srow;
      end
    end
  end

endmodule

### hw/rtl/box_overlay_and_decimating_crop_top.sv
`timescale 1ns / 1ps
// Top level of the box overlay and decimating crop block.
// Depends on bodc_pkg, bodc_boxes and bodc_raster.
//
// Takes one transfer per clock unless stalled, video pixels and detection bytes
// alike; each video pixel yields one result via the input register, then the
// result register; detection bytes return nothing. The rate is set by the
// single pass from input register to result register, in which all stored
// boxes are tested in parallel. Output stall drives input stall combinationally.
// The user writes crop_x0 and crop_y0 only while idle; the block does not enforce it.
module box_overlay_and_decimating_crop_top
  import bodc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CROP_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [PIX_W-1:0]  pixel_in_i,
  input  logic [BYTE_W-1:0] det_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [PIX_W-1:0]  pixel_out_o,
  output logic              frame_start_o,
  output logic              line_end_o,
  output logic              sample_valid_o,
  output logic [PIX_W-1:0]  sample_data_o,
  output logic              sample_last_o
);

  logic [CROP_W-1:0] crop_x0_q, crop_y0_q;
  logic              s1_valid_q;
  command_e          s1_cmd_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              out_valid_q;
  logic [PIX_W-1:0]  pix_out_q, smp_data_q;
  raster_tag_t       tag_q;

  logic              out_free, advance, pix_step, det_step, hit;
  logic [POS_W-1:0]  x, y;
  raster_tag_t       tag;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && ((s1_cmd_q == CMD_DET) || out_free);
  assign pix_step   = advance && (s1_cmd_q == CMD_PIXEL);
  assign det_step   = advance && (s1_cmd_q == CMD_DET);
  assign in_stall_o = s1_valid_q && !advance;

  bodc_boxes u_boxes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .det_step_i (det_step),
    .det_byte_i (s1_byte_q),
    .crop_x0_i  (crop_x0_q),
    .crop_y0_i  (crop_y0_q),
    .x_i        (x),
    .y_i        (y),
    .hit_o      (hit)
  );

  bodc_raster u_raster (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_step_i (pix_step),
    .crop_x0_i  (crop_x0_q),
    .crop_y0_i  (crop_y0_q),
    .x_o        (x),
    .y_o        (y),
    .tag_o      (tag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crop_x0_q <= CROP_W'(320);
      crop_y0_q <= CROP_W'(40);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CROP_X0: crop_x0_q <= cfg_data_i;
        REG_CROP_Y0: crop_y0_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tag_q       <= '0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= pix_step;
      end
      if (pix_step) begin
        tag_q <= tag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_cmd_q  <= command_e'(command_i);
      s1_pix_q  <= pixel_in_i;
      s1_byte_q <= det_byte_i;
    end
    if (pix_step) begin
      pix_out_q  <= hit ? RED_PIXEL : s1_pix_q;
      smp_data_q <= tag.sample_valid ? s1_pix_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = pix_out_q;
  assign frame_start_o  = tag_q.frame_start;
  assign line_end_o     = tag_q.line_end;
  assign sample_valid_o = tag_q.sample_valid;
  assign sample_data_o  = smp_data_q;
  assign sample_last_o  = tag_q.sample_last;

  a_last_is_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_last_o |-> sample_valid_o)
    else $error("last grid sample without sample flag");

  a_no_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> sample_data_o == '0)
    else $error("sample data not cleared");

  a_sample_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_valid_o && pixel_out_o != RED_PIXEL
      |-> pixel_out_o == sample_data_o)
    else $error("unpainted pixel differs from its sample");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_cmd_q == CMD_PIXEL && out_valid_q)
    else $error("input stalled with nothing held");

endmodule
